[hw/rtl/lsrh_pkg.sv]
// ----------------------------------------------------------------------------
// Limit-switch report package
// Shared constants, codes, transfer types and the CRC-8 table for the
// limit-switch report handshake block.
// ----------------------------------------------------------------------------
package lsrh_pkg;

   localparam int FRAME_BITS = 33;
   localparam int BIT_POS_W  = $clog2(FRAME_BITS + 1);
   localparam int DELAY_W    = 16;
   localparam int LEVELS_W   = 5;
   localparam int PHASE_W    = 3;

   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam logic [1:0] REQ_LIMIT_EDGE = 2'd0;
   localparam logic [1:0] REQ_HOST_EDGE  = 2'd1;
   localparam logic [1:0] REQ_TIMER_TICK = 2'd2;

   localparam logic [PHASE_W-1:0] PHASE_IDLE      = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_ATTENTION = 3'd1;
   localparam logic [PHASE_W-1:0] PHASE_ACKED     = 3'd2;
   localparam logic [PHASE_W-1:0] PHASE_CLK_LOW   = 3'd3;
   localparam logic [PHASE_W-1:0] PHASE_CLK_HIGH  = 3'd4;

   localparam logic CSR_FIRST_CHECK_DELAY = 1'b0;
   localparam logic CSR_RETRY_DELAY       = 1'b1;

   typedef struct packed {
      logic                host_level;
      logic [LEVELS_W-1:0] limit_levels;
      logic [1:0]          req_type;
   } item_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               frame_sent;
      logic               tx_level;
   } result_type;

   function automatic logic [7:0] crc_lookup(input logic [7:0] idx);
      logic [7:0] tab [256];
      tab = '{
         8'h00,8'hF7,8'hB9,8'h4E,8'h25,8'hD2,8'h9C,8'h6B,8'h4A,8'hBD,8'hF3,8'h04,8'h6F,8'h98,8'hD6,8'h21,
         8'h94,8'h63,8'h2D,8'hDA,8'hB1,8'h46,8'h08,8'hFF,8'hDE,8'h29,8'h67,8'h90,8'hFB,8'h0C,8'h42,8'hB5,
         8'h7F,8'h88,8'hC6,8'h31,8'h5A,8'hAD,8'hE3,8'h14,8'h35,8'hC2,8'h8C,8'h7B,8'h10,8'hE7,8'hA9,8'h5E,
         8'hEB,8'h1C,8'h52,8'hA5,8'hCE,8'h39,8'h77,8'h80,8'hA1,8'h56,8'h18,8'hEF,8'h84,8'h73,8'h3D,8'hCA,
         8'hFE,8'h09,8'h47,8'hB0,8'hDB,8'h2C,8'h62,8'h95,8'hB4,8'h43,8'h0D,8'hFA,8'h91,8'h66,8'h28,8'hDF,
         8'h6A,8'h9D,8'hD3,8'h24,8'h4F,8'hB8,8'hF6,8'h01,8'h20,8'hD7,8'h99,8'h6E,8'h05,8'hF2,8'hBC,8'h4B,
         8'h81,8'h76,8'h38,8'hCF,8'hA4,8'h53,8'h1D,8'hEA,8'hCB,8'h3C,8'h72,8'h85,8'hEE,8'h19,8'h57,8'hA0,
         8'h15,8'hE2,8'hAC,8'h5B,8'h30,8'hC7,8'h89,8'h7E,8'h5F,8'hA8,8'hE6,8'h11,8'h7A,8'h8D,8'hC3,8'h34,
         8'hAB,8'h5C,8'h12,8'hE5,8'h8E,8'h79,8'h37,8'hC0,8'hE1,8'h16,8'h58,8'hAF,8'hC4,8'h33,8'h7D,8'h8A,
         8'h3F,8'hC8,8'h86,8'h71,8'h1A,8'hED,8'hA3,8'h54,8'h75,8'h82,8'hCC,8'h3B,8'h50,8'hA7,8'hE9,8'h1E,
         8'hD4,8'h23,8'h6D,8'h9A,8'hF1,8'h06,8'h48,8'hBF,8'h9E,8'h69,8'h27,8'hD0,8'hBB,8'h4C,8'h02,8'hF5,
         8'h40,8'hB7,8'hF9,8'h0E,8'h65,8'h92,8'hDC,8'h2B,8'h0A,8'hFD,8'hB3,8'h44,8'h2F,8'hD8,8'h96,8'h61,
         8'h55,8'hA2,8'hEC,8'h1B,8'h70,8'h87,8'hC9,8'h3E,8'h1F,8'hE8,8'hA6,8'h51,8'h3A,8'hCD,8'h83,8'h74,
         8'hC1,8'h36,8'h78,8'h8F,8'hE4,8'h13,8'h5D,8'hAA,8'h8B,8'h7C,8'h32,8'hC5,8'hAE,8'h59,8'h17,8'hE0,
         8'h2A,8'hDD,8'h93,8'h64,8'h0F,8'hF8,8'hB6,8'h41,8'h60,8'h97,8'hD9,8'h2E,8'h45,8'hB2,8'hFC,8'h0B,
         8'hBE,8'h49,8'h07,8'hF0,8'h9B,8'h6C,8'h22,8'hD5,8'hF4,8'h03,8'h4D,8'hBA,8'hD1,8'h26,8'h68,8'h9F
      };
      return tab[idx];
   endfunction

   // CRC over the limit byte followed by two zero bytes.
   function automatic logic [7:0] frame_crc(input logic [LEVELS_W-1:0] levels);
      logic [7:0] c;
      c = crc_lookup(CRC_INIT ^ {{(8-LEVELS_W){1'b0}}, levels});
      c = crc_lookup(c);
      c = crc_lookup(c);
      return c;
   endfunction

endpackage

[hw/rtl/lsrh_engine.sv]
// ----------------------------------------------------------------------------
// Limit-switch report engine
// Holds the handshake state and applies one item per enabled cycle, giving
// the result of that item combinationally.
// ----------------------------------------------------------------------------
module lsrh_engine
   import lsrh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  item_type           item,
   input  logic [DELAY_W-1:0] first_check_delay,
   input  logic [DELAY_W-1:0] retry_delay,
   output result_type         result
);

   logic [PHASE_W-1:0]    phase_ff,     phase_in;
   logic [FRAME_BITS-1:0] frame_ff,     frame_in;
   logic [FRAME_BITS-1:0] last_sent_ff, last_sent_in;
   logic [BIT_POS_W-1:0]  bit_pos_ff,   bit_pos_in;
   logic                  pending_ff,   pending_in;
   logic [DELAY_W-1:0]    timer_ff,     timer_in;
   logic                  armed_ff,     armed_in;
   logic                  line_ff,      line_in;

   logic                  sent;
   logic [63:0]           frame_wide;
   logic [FRAME_BITS-1:0] frame_new;
   logic [FRAME_BITS-1:0] frame_shift;
   logic [DELAY_W-1:0]    first_load;
   logic [DELAY_W-1:0]    retry_load;

   assign frame_wide  = {32'd0, frame_crc(item.limit_levels), 16'd0,
                         {(8-LEVELS_W){1'b0}}, item.limit_levels};
   assign frame_new   = frame_wide[FRAME_BITS-1:0];
   assign frame_shift = frame_ff >> bit_pos_ff;
   assign first_load  = (first_check_delay == '0) ? DELAY_W'(1) : first_check_delay;
   assign retry_load  = (retry_delay == '0) ? DELAY_W'(1) : retry_delay;

   always_comb begin
      phase_in     = phase_ff;
      frame_in     = frame_ff;
      last_sent_in = last_sent_ff;
      bit_pos_in   = bit_pos_ff;
      pending_in   = pending_ff;
      timer_in     = timer_ff;
      armed_in     = armed_ff;
      line_in      = line_ff;
      sent         = 1'b0;

      case (item.req_type)
         REQ_LIMIT_EDGE: begin
            if (phase_ff == PHASE_IDLE) begin
               frame_in = frame_new;
               if (frame_new != last_sent_ff) begin
                  phase_in = PHASE_ATTENTION;
                  line_in  = 1'b1;
                  timer_in = first_load;
                  armed_in = 1'b1;
               end
            end else begin
               pending_in = 1'b1;
            end
         end
         REQ_HOST_EDGE: begin
            case (phase_ff)
               PHASE_ATTENTION: begin
                  if (!item.host_level) begin
                     phase_in = PHASE_ACKED;
                  end
               end
               PHASE_ACKED: begin
                  if (item.host_level) begin
                     bit_pos_in = '0;
                     line_in    = 1'b0;
                     phase_in   = PHASE_CLK_LOW;
                  end
               end
               PHASE_CLK_LOW: begin
                  if (!item.host_level) begin
                     if (bit_pos_ff < BIT_POS_W'(FRAME_BITS)) begin
                        line_in    = frame_shift[0];
                        bit_pos_in = bit_pos_ff + BIT_POS_W'(1);
                        phase_in   = PHASE_CLK_HIGH;
                     end else begin
                        armed_in     = 1'b0;
                        timer_in     = '0;
                        line_in      = 1'b0;
                        phase_in     = PHASE_IDLE;
                        last_sent_in = frame_ff;
                        sent         = 1'b1;
                        if (pending_ff) begin
                           pending_in = 1'b0;
                           timer_in   = retry_load;
                           armed_in   = 1'b1;
                        end
                     end
                  end
               end
               PHASE_CLK_HIGH: begin
                  if (item.host_level) begin
                     phase_in = PHASE_CLK_LOW;
                  end
               end
               default: begin
               end
            endcase
         end
         REQ_TIMER_TICK: begin
            if (armed_ff) begin
               if (timer_ff <= DELAY_W'(1)) begin
                  armed_in = 1'b0;
                  timer_in = '0;
                  if (phase_ff == PHASE_IDLE) begin
                     frame_in = frame_new;
                     if (frame_new != last_sent_ff) begin
                        phase_in = PHASE_ATTENTION;
                        line_in  = 1'b1;
                        timer_in = first_load;
                        armed_in = 1'b1;
                     end
                  end else begin
                     timer_in = retry_load;
                     armed_in = 1'b1;
                  end
               end else begin
                  timer_in = timer_ff - DELAY_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         frame_ff     <= '0;
         last_sent_ff <= '1;
         bit_pos_ff   <= '0;
         pending_ff   <= 1'b0;
         timer_ff     <= '0;
         armed_ff     <= 1'b0;
         line_ff      <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         frame_ff     <= frame_in;
         last_sent_ff <= last_sent_in;
         bit_pos_ff   <= bit_pos_in;
         pending_ff   <= pending_in;
         timer_ff     <= timer_in;
         armed_ff     <= armed_in;
         line_ff      <= line_in;
      end
   end

   assign result.tx_level   = line_in;
   assign result.frame_sent = sent;
   assign result.phase      = phase_in;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_CLK_HIGH)
      else $error("Phase register left its legal range.");

   a_timer_armed: assert property (@(posedge clock) disable iff (reset)
      armed_ff == (timer_ff != '0))
      else $error("Timer count and armed flag disagree.");

   a_line_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_IDLE) |-> !line_ff)
      else $error("Line driven high while idle.");

   a_bit_pos: assert property (@(posedge clock) disable iff (reset)
      bit_pos_ff <= BIT_POS_W'(FRAME_BITS))
      else $error("Bit position ran past the frame.");

   a_sent_ends: assert property (@(posedge clock) disable iff (reset)
      (step_en && sent) |=> (phase_ff == PHASE_IDLE && last_sent_ff == $past(frame_ff)))
      else $error("Finished frame was not recorded.");

endmodule

[hw/rtl/limit_switch_report_handshake_core.sv]
// ----------------------------------------------------------------------------
// Limit-switch report handshake core
// Stream wrapper: input register, handshake engine and result register,
// plus the two delay registers.
// ----------------------------------------------------------------------------
// A result is offered on rsp once its req transfer has passed the input and result registers.
// Throughput: one item per cycle while rsp_tready does not stall the result register; the
// engine state updates as an item moves from the input register into the result register.
// Reset: synchronous, active high; clears the valid flags of both pipeline registers and
// the engine state, and loads the delay registers with 16000 and 1000.
module limit_switch_report_handshake_core
   import lsrh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] limit_levels, [5] host_level, [7:6] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] tx_level, [3:1] phase, [7:4] zero
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   logic               in_valid_ff;
   item_type           in_item_ff;
   logic               out_valid_ff;
   result_type         out_result_ff;
   logic [DELAY_W-1:0] first_delay_ff;
   logic [DELAY_W-1:0] retry_delay_ff;
   logic               advance;
   result_type         result;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.req_type     <= req_tuser;
         in_item_ff.limit_levels <= req_tdata[LEVELS_W-1:0];
         in_item_ff.host_level   <= req_tdata[LEVELS_W];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_delay_ff <= DELAY_W'(16000);
         retry_delay_ff <= DELAY_W'(1000);
      end else if (csr_we) begin
         case (csr_addr)
            CSR_FIRST_CHECK_DELAY: first_delay_ff <= csr_wdata;
            CSR_RETRY_DELAY:       retry_delay_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lsrh_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .step_en           (advance),
      .item              (in_item_ff),
      .first_check_delay (first_delay_ff),
      .retry_delay       (retry_delay_ff),
      .result            (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_result_ff.phase, out_result_ff.tx_level};
   assign rsp_tlast  = out_result_ff.frame_sent;

endmodule

[tb/sv/limit_switch_report_handshake_core_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Limit-switch report handshake checker
// Watches the request, result and register ports of the core, keeps its own
// copy of the report engine and compares every result transfer, field by
// field, with the oldest report still awaited.
// ----------------------------------------------------------------------------
module limit_switch_report_handshake_core_checker
   import lsrh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [4:0] limit_levels, [5] host_level, [7:6] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [0] tx_level, [3:1] phase, [7:4] zero
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata,
   output int          failures,
   output int          pending
);

   localparam logic [7:0]         CRC_POLY_REFL = 8'hAB;
   localparam logic [DELAY_W-1:0] FIRST_DEFAULT = 16'd16000;
   localparam logic [DELAY_W-1:0] RETRY_DEFAULT = 16'd1000;

   logic [PHASE_W-1:0]    phase_q;
   logic [FRAME_BITS-1:0] frame_word;
   logic [FRAME_BITS-1:0] last_frame;
   logic [6:0]            bit_q;
   logic                  change_seen;
   logic [DELAY_W-1:0]    count_q;
   logic                  armed_q;
   logic                  line_q;
   logic [DELAY_W-1:0]    first_delay;
   logic [DELAY_W-1:0]    retry_delay;

   result_type expected_reports[$];

   initial begin
      failures = 0;
      pending = 0;
   end

   task automatic report_fault(input string msg);
      $display("%0t ns: MISMATCH %s", $time, msg);
      failures++;
   endtask

   // One byte through the reflected CRC-8 register.
   function automatic logic [7:0] crc_byte(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
      end
      return r;
   endfunction

   function automatic void arm_ticks(input logic [DELAY_W-1:0] delay);
      count_q = (delay == '0) ? 16'd1 : delay;
      armed_q = 1'b1;
   endfunction

   function automatic void capture_levels(input logic [LEVELS_W-1:0] levels);
      logic [7:0]            c;
      logic [FRAME_BITS-1:0] f;
      c = crc_byte(CRC_INIT ^ {{(8-LEVELS_W){1'b0}}, levels});
      c = crc_byte(c);
      c = crc_byte(c);
      f = '0;
      f[LEVELS_W-1:0] = levels;
      f[31:24] = c;
      frame_word = f;
      if (f != last_frame) begin
         phase_q = PHASE_ATTENTION;
         line_q = 1'b1;
         arm_ticks(first_delay);
      end
   endfunction

   function automatic result_type predict_report(input logic [1:0] kind,
                                                 input logic [LEVELS_W-1:0] levels,
                                                 input logic host);
      result_type r;
      logic       done;
      done = 1'b0;
      case (kind)
         REQ_LIMIT_EDGE: begin
            if (phase_q == PHASE_IDLE) capture_levels(levels);
            else change_seen = 1'b1;
         end
         REQ_HOST_EDGE: begin
            case (phase_q)
               PHASE_ATTENTION: begin
                  if (!host) phase_q = PHASE_ACKED;
               end
               PHASE_ACKED: begin
                  if (host) begin
                     bit_q = '0;
                     line_q = 1'b0;
                     phase_q = PHASE_CLK_LOW;
                  end
               end
               PHASE_CLK_LOW: begin
                  if (!host && bit_q < FRAME_BITS) begin
                     line_q = frame_word[bit_q];
                     bit_q = bit_q + 7'd1;
                     phase_q = PHASE_CLK_HIGH;
                  end else if (!host) begin
                     armed_q = 1'b0;
                     count_q = '0;
                     line_q = 1'b0;
                     phase_q = PHASE_IDLE;
                     last_frame = frame_word;
                     done = 1'b1;
                     if (change_seen) begin
                        change_seen = 1'b0;
                        arm_ticks(retry_delay);
                     end
                  end
               end
               PHASE_CLK_HIGH: begin
                  if (host) phase_q = PHASE_CLK_LOW;
               end
               default: ;
            endcase
         end
         REQ_TIMER_TICK: begin
            if (armed_q && count_q <= 16'd1) begin
               armed_q = 1'b0;
               count_q = '0;
               if (phase_q == PHASE_IDLE) capture_levels(levels);
               else arm_ticks(retry_delay);
            end else if (armed_q) begin
               count_q = count_q - 16'd1;
            end
         end
         default: ;
      endcase
      r.tx_level = line_q;
      r.frame_sent = done;
      r.phase = phase_q;
      return r;
   endfunction

   task automatic check_report(input logic [7:0] data, input logic last);
      result_type want;
      result_type got;
      got.tx_level = data[0];
      got.frame_sent = last;
      got.phase = data[3:1];
      if (expected_reports.size() == 0) begin
         report_fault($sformatf("result 0x%02h last %0d arrived with no report awaited",
                                data, last));
         return;
      end
      want = expected_reports.pop_front();
      if (got.tx_level !== want.tx_level)
         report_fault($sformatf("tx_level: got %0d, expected %0d", got.tx_level,
                                want.tx_level));
      if (got.frame_sent !== want.frame_sent)
         report_fault($sformatf("frame_sent: got %0d, expected %0d", got.frame_sent,
                                want.frame_sent));
      if (got.phase !== want.phase)
         report_fault($sformatf("phase: got %0d, expected %0d", got.phase, want.phase));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase_q = PHASE_IDLE;
         frame_word = '0;
         last_frame = '1;
         bit_q = '0;
         change_seen = 1'b0;
         count_q = '0;
         armed_q = 1'b0;
         line_q = 1'b0;
         first_delay = FIRST_DEFAULT;
         retry_delay = RETRY_DEFAULT;
         expected_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_FIRST_CHECK_DELAY: first_delay = csr_wdata;
               CSR_RETRY_DELAY:       retry_delay = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_report(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready)
            expected_reports.push_back(predict_report(req_tuser, req_tdata[4:0],
                                                      req_tdata[5]));
      end
      pending = expected_reports.size();
   end

endmodule

[tb/sv/limit_switch_report_handshake_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Limit-switch report handshake core testbench
// Drives short directed cases and then whole report sessions (limit change,
// host acknowledge, one clock pair per frame bit, closing edge) laced with
// timer ticks, stray edges and cut-off sessions, under several delay
// settings and random gaps on both channels. A checker beside the core
// predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module limit_switch_report_handshake_core_tb;
   import lsrh_pkg::*;

   localparam logic [1:0] REQ_NO_OP = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [4:0] limit_levels, [5] host_level, [7:6] zero
   logic [1:0]  req_tuser = '0;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] tx_level, [3:1] phase, [7:4] zero
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [15:0] csr_wdata = '0;

   int   failures;
   int   pending;
   int   items_sent = 0;
   logic idling_on = 1'b1;
   logic [LEVELS_W-1:0] last_levels = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   limit_switch_report_handshake_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   limit_switch_report_handshake_core_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            hold--;
         end else begin
            rsp_tready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [LEVELS_W-1:0] levels,
                            input logic host);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, host, levels};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_noise();
      int r;
      logic [1:0] kind;
      logic [LEVELS_W-1:0] levels;
      logic host;
      r = $urandom_range(0, 99);
      levels = $urandom_range(0, 31);
      host = $urandom_range(0, 1);
      if (r < 40) kind = REQ_TIMER_TICK;
      else if (r < 60) kind = REQ_LIMIT_EDGE;
      else if (r < 85) kind = REQ_HOST_EDGE;
      else kind = REQ_NO_OP;
      send_item(kind, levels, host);
   endtask

   // A limit change followed by the host's acknowledge, one falling and rising
   // edge per frame bit and the closing falling edge; some sessions break off.
   task automatic run_frame(input logic [LEVELS_W-1:0] levels, input int noise_pct);
      int last_step;
      int step;
      logic [LEVELS_W-1:0] junk;
      last_step = 2 * FRAME_BITS + 3;
      if ($urandom_range(0, 99) < 10) last_step = $urandom_range(0, last_step - 1);
      for (step = 0; step <= last_step; step++) begin
         if ($urandom_range(0, 99) < noise_pct) send_noise();
         junk = $urandom_range(0, 31);
         if (step == 0) send_item(REQ_LIMIT_EDGE, levels, 1'b1);
         else send_item(REQ_HOST_EDGE, junk, ~step[0]);
      end
   endtask

   task automatic run_phase(input int n_items, input int noise_pct);
      int goal;
      logic [LEVELS_W-1:0] levels;
      goal = items_sent + n_items;
      while (items_sent < goal) begin
         levels = $urandom_range(0, 31);
         if ($urandom_range(0, 99) < 15) levels = last_levels;
         run_frame(levels, noise_pct);
         last_levels = levels;
         repeat ($urandom_range(0, 4)) send_noise();
      end
   endtask

   task automatic write_delay(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A zero retry delay must behave as one tick.
      write_delay(CSR_FIRST_CHECK_DELAY, 16'd2);
      write_delay(CSR_RETRY_DELAY, 16'd0);
      send_item(REQ_NO_OP, 5'h00, 1'b0);
      send_item(REQ_HOST_EDGE, 5'h00, 1'b0);
      send_item(REQ_TIMER_TICK, 5'h1F, 1'b1);
      send_item(REQ_LIMIT_EDGE, 5'h00, 1'b0);
      send_item(REQ_HOST_EDGE, 5'h1F, 1'b1);
      send_item(REQ_TIMER_TICK, 5'h00, 1'b0);
      send_item(REQ_TIMER_TICK, 5'h1F, 1'b1);
      send_item(REQ_HOST_EDGE, 5'h00, 1'b0);
      send_item(REQ_HOST_EDGE, 5'h15, 1'b0);
      send_item(REQ_LIMIT_EDGE, 5'h1F, 1'b1);
      send_item(REQ_HOST_EDGE, 5'h0A, 1'b1);
      send_item(REQ_HOST_EDGE, 5'h00, 1'b1);
      send_item(REQ_HOST_EDGE, 5'h1F, 1'b0);
      send_item(REQ_HOST_EDGE, 5'h00, 1'b0);
      send_item(REQ_HOST_EDGE, 5'h1F, 1'b1);
      send_item(REQ_TIMER_TICK, 5'h00, 1'b1);
      send_item(REQ_NO_OP, 5'h1F, 1'b1);
      settle();

      write_delay(CSR_FIRST_CHECK_DELAY, 16'd1);
      write_delay(CSR_RETRY_DELAY, 16'd1);
      run_phase(450, 6);
      settle();

      idling_on = 1'b0;
      write_delay(CSR_FIRST_CHECK_DELAY, 16'd65535);
      write_delay(CSR_RETRY_DELAY, 16'd65535);
      run_phase(450, 10);
      settle();

      idling_on = 1'b1;
      write_delay(CSR_FIRST_CHECK_DELAY, 16'd3);
      write_delay(CSR_RETRY_DELAY, 16'd2);
      run_phase(450, 8);
      settle();

      write_delay(CSR_FIRST_CHECK_DELAY, 16'd65535);
      write_delay(CSR_RETRY_DELAY, 16'd1);
      run_phase(450, 8);
      settle();

      repeat (8) @(negedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout: run limit reached before all results arrived");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
